[hw/rtl/twm_pkg.sv]
package twm_pkg;

  localparam int unsigned CSP_START_W = 10;
  localparam int unsigned CSP_W       = 32;

  // fixed words
  localparam int unsigned IP_WORD   = 1;
  localparam int unsigned FLAG_WORD = 3;
  localparam int unsigned SP_WORD   = 10;
  localparam int unsigned SP_START  = 10;

  // request kinds
  localparam logic [1:0] REQ_APPEND = 2'd0;
  localparam logic [1:0] REQ_START  = 2'd1;
  localparam logic [1:0] REQ_EXEC   = 2'd2;

  // fault codes
  localparam logic [1:0] FLT_NONE   = 2'd0;
  localparam logic [1:0] FLT_RANGE  = 2'd1;
  localparam logic [1:0] FLT_OPCODE = 2'd2;
  localparam logic [1:0] FLT_FULL   = 2'd3;

  // opcodes
  localparam logic [7:0] OPC_NOP  = 8'd0;
  localparam logic [7:0] OPC_SKIP = 8'd1;
  localparam logic [7:0] OPC_MOV  = 8'd2;
  localparam logic [7:0] OPC_SET  = 8'd3;
  localparam logic [7:0] OPC_IN   = 8'd4;
  localparam logic [7:0] OPC_OUT  = 8'd5;
  localparam logic [7:0] OPC_INC  = 8'd6;
  localparam logic [7:0] OPC_DEC  = 8'd7;
  localparam logic [7:0] OPC_ADD  = 8'd8;
  localparam logic [7:0] OPC_SUB  = 8'd9;
  localparam logic [7:0] OPC_CMP  = 8'd10;
  localparam logic [7:0] OPC_JCC  = 8'd11;
  localparam logic [7:0] OPC_JBK  = 8'd12;
  localparam logic [7:0] OPC_JFW  = 8'd13;
  localparam logic [7:0] OPC_OUTC = 8'd14;
  localparam logic [7:0] OPC_NOPB = 8'd15;
  localparam logic [7:0] OPC_NOPC = 8'd16;
  localparam logic [7:0] OPC_NOPD = 8'd17;
  localparam logic [7:0] OPC_RET  = 8'd18;
  localparam logic [7:0] OPC_CALL = 8'd19;
  localparam logic [7:0] OPC_PUSH = 8'd20;
  localparam logic [7:0] OPC_POP  = 8'd21;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  word_opcode;
    logic [31:0] word_dest;
    logic [31:0] word_source;
    logic [31:0] input_value;
  } in_req_t;

  typedef struct packed {
    logic        out_valid;
    logic        out_is_char;
    logic [31:0] out_value;
    logic        input_taken;
    logic        running;
    logic [1:0]  fault;
    logic [31:0] next_ip;
  } out_res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_APPEND,
    ST_START_IP,
    ST_START_SP,
    ST_X_IP,
    ST_X_FETCH,
    ST_X_DEC,
    ST_X_SP,
    ST_X_A,
    ST_X_B,
    ST_X_W1,
    ST_X_W2,
    ST_INC_RD,
    ST_INC_WR,
    ST_FIN_RD,
    ST_FIN
  } state_t;

  function automatic logic op_reads_a(input logic [7:0] opc);
    case (opc) inside
      OPC_SKIP, OPC_MOV, OPC_OUT, OPC_INC, OPC_DEC, OPC_ADD, OPC_SUB, OPC_CMP,
      OPC_JCC, OPC_RET, OPC_PUSH, OPC_POP: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic op_reads_b(input logic [7:0] opc);
    case (opc) inside
      OPC_ADD, OPC_SUB, OPC_CMP: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic op_sets_ip(input logic [7:0] opc);
    case (opc) inside
      OPC_SKIP, OPC_JCC, OPC_JBK, OPC_JFW: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic op_two_writes(input logic [7:0] opc);
    case (opc) inside
      OPC_RET, OPC_CALL, OPC_PUSH, OPC_POP: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

endpackage

[hw/rtl/twm_store.sv]
module twm_store #(
  parameter int DEPTH = 1024,
  parameter int W     = 32,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          opc_we,
  input  logic          dst_we,
  input  logic [AW-1:0] dst_waddr,
  input  logic [7:0]    opc_wdata,
  input  logic [W-1:0]  dst_wdata,
  input  logic [AW-1:0] dst_raddr,
  output logic [7:0]    opc_q,
  output logic [W-1:0]  dst_q,
  input  logic          src_we,
  input  logic [AW-1:0] src_waddr,
  input  logic [W-1:0]  src_wdata,
  input  logic [AW-1:0] src_raddr,
  output logic [W-1:0]  src_q
);

  logic [7:0]   opc_mem [DEPTH];
  logic [W-1:0] dst_mem [DEPTH];
  logic [W-1:0] src_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (opc_we) begin
      opc_mem[dst_waddr] <= opc_wdata;
    end
    if (dst_we) begin
      dst_mem[dst_waddr] <= dst_wdata;
    end
    opc_q <= opc_mem[dst_raddr];
    dst_q <= dst_mem[dst_raddr];
  end

  always_ff @(posedge clk) begin
    if (src_we) begin
      src_mem[src_waddr] <= src_wdata;
    end
    src_q <= src_mem[src_raddr];
  end

endmodule

[hw/rtl/triple_word_machine_core.sv]
// word-addressed machine core
// requests enter on in_req when start is high and busy is low; a request appends
// a program word, starts a run or executes one instruction; the unused kind only reports. every request gives
// exactly one result on out_res, shown for one cycle with out_strobe high.
// the source field memory has one read port with a registered read, and each
// instruction walks through its dependent reads (ip word, instruction, stack
// word, operands) and its writes one access per cycle; that port sets how long
// a request takes, which for execute depends on the opcode.
// busy drops in the cycle the result is shown, so a new request may be taken
// while the result is on the ports. the receiver cannot stall.
// cfg_we writes the call stack start register; write it only while idle.
// reset clears the program length, the call stack pointer, the configuration
// register and the sequencer; memory contents stay undefined until written.
module triple_word_machine_core import twm_pkg::*; #(
  parameter int MEM_DEPTH  = 1024,
  parameter int WORD_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  in_req_t                in_req,
  output logic                   out_strobe,
  output out_res_t               out_res,
  input  logic                   cfg_we,
  input  logic [CSP_START_W-1:0] cfg_wdata
);

  localparam int AW  = $clog2(MEM_DEPTH);
  localparam int PW  = $clog2(MEM_DEPTH + 1);
  localparam int W   = WORD_WIDTH;
  localparam int CW0 = (W > CSP_W) ? W : CSP_W;
  localparam int CW  = (CW0 > PW) ? CW0 : PW;

  function automatic logic in_rng(input logic [CW-1:0] x, input logic [PW-1:0] len);
    return x < CW'(len);
  endfunction

  state_t state_r, state_nxt;
  in_req_t req_r, req_nxt;
  logic [PW-1:0] plen_r, plen_nxt;
  logic [CSP_W-1:0] csp_r, csp_nxt;
  logic [CSP_START_W-1:0] csp_start_r;
  logic [W-1:0] ip_r, ip_nxt, d_r, d_nxt, s_r, s_nxt, sp_r, sp_nxt;
  logic [W-1:0] a_r, a_nxt, b_r, b_nxt, flagd_r, flagd_nxt, outv_r, outv_nxt;
  logic [7:0] opc_r, opc_nxt;
  logic valid_r, valid_nxt, char_r, char_nxt, taken_r, taken_nxt;
  logic [1:0] fault_r, fault_nxt, chk_fault;
  logic out_strobe_r, out_strobe_nxt;
  out_res_t out_res_r, out_res_nxt;

  logic          opc_we, dst_we, src_we;
  logic [AW-1:0] dst_waddr, dst_raddr, src_waddr, src_raddr;
  logic [7:0]    opc_wdata, opc_q;
  logic [W-1:0]  dst_wdata, dst_q, src_wdata, src_q;

  logic              accept;
  logic [CSP_W-1:0]  csp_inc;
  logic [W-1:0]      ip_back, ip_fwd, sp_inc;

  assign accept  = start && !busy;
  assign busy    = (state_r != ST_IDLE);
  assign csp_inc = csp_r + 1'b1;
  assign ip_back = ip_r - s_r;
  assign ip_fwd  = ip_r + s_r;
  assign sp_inc  = sp_r + 1'b1;

  twm_store #(.DEPTH(MEM_DEPTH), .W(W)) u_store (
    .clk       (clk),
    .opc_we    (opc_we),
    .dst_we    (dst_we),
    .dst_waddr (dst_waddr),
    .opc_wdata (opc_wdata),
    .dst_wdata (dst_wdata),
    .dst_raddr (dst_raddr),
    .opc_q     (opc_q),
    .dst_q     (dst_q),
    .src_we    (src_we),
    .src_waddr (src_waddr),
    .src_wdata (src_wdata),
    .src_raddr (src_raddr),
    .src_q     (src_q)
  );

  // operand index checks, stack word arrives on src_q in ST_X_SP
  always_comb begin
    logic r_d, r_s;
    r_d = in_rng(CW'(d_r), plen_r);
    r_s = in_rng(CW'(s_r), plen_r);
    case (opc_r) inside
      OPC_NOP, OPC_NOPB, OPC_OUTC: chk_fault = FLT_NONE;
      OPC_SKIP, OPC_IN, OPC_OUT, OPC_INC, OPC_DEC, OPC_NOPC, OPC_NOPD:
        chk_fault = r_s ? FLT_NONE : FLT_RANGE;
      OPC_MOV, OPC_ADD, OPC_SUB, OPC_CMP, OPC_JCC:
        chk_fault = (r_d && r_s) ? FLT_NONE : FLT_RANGE;
      OPC_SET: chk_fault = r_d ? FLT_NONE : FLT_RANGE;
      OPC_JBK:
        chk_fault = (r_s && in_rng(CW'(ip_back), plen_r)) ? FLT_NONE : FLT_RANGE;
      OPC_JFW:
        chk_fault = (r_s && in_rng(CW'(ip_fwd), plen_r)) ? FLT_NONE : FLT_RANGE;
      OPC_RET: chk_fault = in_rng(CW'(csp_r), plen_r) ? FLT_NONE : FLT_RANGE;
      OPC_CALL:
        chk_fault = (r_s && in_rng(CW'(csp_inc), plen_r)) ? FLT_NONE : FLT_RANGE;
      OPC_PUSH:
        chk_fault = (r_s && in_rng(CW'(W'(src_q + 1'b1)), plen_r)) ? FLT_NONE : FLT_RANGE;
      OPC_POP:
        chk_fault = (r_s && in_rng(CW'(src_q), plen_r)) ? FLT_NONE : FLT_RANGE;
      default: chk_fault = FLT_OPCODE;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_req.op)
            REQ_APPEND: state_nxt = ST_APPEND;
            REQ_START:  state_nxt = ST_START_IP;
            REQ_EXEC:   state_nxt = ST_X_IP;
            default:    state_nxt = ST_FIN_RD;
          endcase
        end
      end
      ST_APPEND:   state_nxt = ST_FIN_RD;
      ST_START_IP: state_nxt = ST_START_SP;
      ST_START_SP: state_nxt = ST_FIN_RD;
      ST_X_IP:     state_nxt = ST_X_FETCH;
      ST_X_FETCH:  state_nxt = in_rng(CW'(src_q), plen_r) ? ST_X_DEC : ST_FIN_RD;
      ST_X_DEC:    state_nxt = ST_X_SP;
      ST_X_SP: begin
        if (chk_fault != FLT_NONE) begin
          state_nxt = ST_FIN_RD;
        end else if (op_reads_a(opc_r)) begin
          state_nxt = ST_X_A;
        end else begin
          state_nxt = ST_X_W1;
        end
      end
      ST_X_A:  state_nxt = op_reads_b(opc_r) ? ST_X_B : ST_X_W1;
      ST_X_B:  state_nxt = ST_X_W1;
      ST_X_W1: begin
        if (op_sets_ip(opc_r)) begin
          state_nxt = ST_FIN_RD;
        end else if (op_two_writes(opc_r)) begin
          state_nxt = ST_X_W2;
        end else begin
          state_nxt = ST_INC_RD;
        end
      end
      ST_X_W2:   state_nxt = ST_INC_RD;
      ST_INC_RD: state_nxt = ST_INC_WR;
      ST_INC_WR: state_nxt = ST_FIN_RD;
      ST_FIN_RD: state_nxt = ST_FIN;
      ST_FIN:    state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // memory controls and datapath
  always_comb begin
    opc_we = 1'b0;
    dst_we = 1'b0;
    src_we = 1'b0;
    dst_waddr = AW'(plen_r);
    opc_wdata = req_r.word_opcode;
    dst_wdata = W'(req_r.word_dest);
    dst_raddr = AW'(FLAG_WORD);
    src_waddr = AW'(IP_WORD);
    src_wdata = '0;
    src_raddr = AW'(IP_WORD);
    req_nxt = req_r;
    plen_nxt = plen_r;
    csp_nxt = csp_r;
    ip_nxt = ip_r;
    opc_nxt = opc_r;
    d_nxt = d_r;
    s_nxt = s_r;
    sp_nxt = sp_r;
    a_nxt = a_r;
    b_nxt = b_r;
    flagd_nxt = flagd_r;
    outv_nxt = outv_r;
    valid_nxt = valid_r;
    char_nxt = char_r;
    taken_nxt = taken_r;
    fault_nxt = fault_r;
    out_strobe_nxt = 1'b0;
    out_res_nxt = out_res_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          req_nxt = in_req;
          outv_nxt = '0;
          valid_nxt = 1'b0;
          char_nxt = 1'b0;
          taken_nxt = 1'b0;
          fault_nxt = FLT_NONE;
        end
      end
      ST_APPEND: begin
        if (plen_r == PW'(MEM_DEPTH)) begin
          fault_nxt = FLT_FULL;
        end else begin
          opc_we = 1'b1;
          dst_we = 1'b1;
          src_we = 1'b1;
          src_waddr = AW'(plen_r);
          src_wdata = W'(req_r.word_source);
          plen_nxt = plen_r + 1'b1;
        end
      end
      ST_START_IP: begin
        src_we = 1'b1;
        src_waddr = AW'(IP_WORD);
        src_wdata = '0;
        csp_nxt = CSP_W'(csp_start_r);
      end
      ST_START_SP: begin
        src_we = 1'b1;
        src_waddr = AW'(SP_WORD);
        src_wdata = W'(SP_START);
      end
      ST_X_IP: src_raddr = AW'(IP_WORD);
      ST_X_FETCH: begin
        ip_nxt = src_q;
        src_raddr = AW'(src_q);
        dst_raddr = AW'(src_q);
      end
      ST_X_DEC: begin
        opc_nxt = opc_q;
        d_nxt = dst_q;
        s_nxt = src_q;
        src_raddr = AW'(SP_WORD);
      end
      ST_X_SP: begin
        sp_nxt = src_q;
        fault_nxt = chk_fault;
        dst_raddr = AW'(FLAG_WORD);
        case (opc_r) inside
          OPC_SKIP: src_raddr = AW'(IP_WORD);
          OPC_ADD, OPC_SUB, OPC_CMP: src_raddr = AW'(d_r);
          OPC_JCC: src_raddr = AW'(FLAG_WORD);
          OPC_RET: src_raddr = AW'(csp_r);
          OPC_POP: src_raddr = AW'(src_q);
          default: src_raddr = AW'(s_r);
        endcase
      end
      ST_X_A: begin
        a_nxt = src_q;
        flagd_nxt = dst_q;
        src_raddr = AW'(s_r);
      end
      ST_X_B: b_nxt = src_q;
      ST_X_W1: begin
        case (opc_r)
          OPC_SKIP: begin
            src_we = 1'b1;
            src_wdata = a_r + s_r + 1'b1;
          end
          OPC_MOV: begin
            src_we = 1'b1;
            src_waddr = AW'(d_r);
            src_wdata = a_r;
          end
          OPC_SET: begin
            src_we = 1'b1;
            src_waddr = AW'(d_r);
            src_wdata = s_r;
          end
          OPC_IN: begin
            src_we = 1'b1;
            src_waddr = AW'(s_r);
            src_wdata = W'(req_r.input_value);
            taken_nxt = 1'b1;
          end
          OPC_OUT: begin
            outv_nxt = a_r;
            valid_nxt = 1'b1;
          end
          OPC_INC: begin
            src_we = 1'b1;
            src_waddr = AW'(s_r);
            src_wdata = a_r + 1'b1;
          end
          OPC_DEC: begin
            src_we = 1'b1;
            src_waddr = AW'(s_r);
            src_wdata = a_r - 1'b1;
          end
          OPC_ADD: begin
            src_we = 1'b1;
            src_waddr = AW'(d_r);
            src_wdata = a_r + b_r;
          end
          OPC_SUB: begin
            src_we = 1'b1;
            src_waddr = AW'(d_r);
            src_wdata = a_r - b_r;
          end
          OPC_CMP: begin
            dst_we = 1'b1;
            dst_waddr = AW'(FLAG_WORD);
            dst_wdata = W'(a_r == b_r);
            src_we = 1'b1;
            src_waddr = AW'(FLAG_WORD);
            src_wdata = W'(a_r != b_r);
          end
          OPC_JCC: begin
            src_we = 1'b1;
            src_wdata = (flagd_r == W'(1) && a_r == '0) ? d_r : s_r;
          end
          OPC_JBK: begin
            src_we = 1'b1;
            src_wdata = ip_back;
          end
          OPC_JFW: begin
            src_we = 1'b1;
            src_wdata = ip_fwd;
          end
          OPC_OUTC: begin
            outv_nxt = W'(s_r[7:0]);
            valid_nxt = 1'b1;
            char_nxt = 1'b1;
          end
          OPC_RET: begin
            src_we = 1'b1;
            src_wdata = a_r;
          end
          OPC_CALL: begin
            src_we = 1'b1;
            src_waddr = AW'(csp_inc);
            src_wdata = ip_r;
            csp_nxt = csp_inc;
          end
          OPC_PUSH: begin
            src_we = 1'b1;
            src_waddr = AW'(SP_WORD);
            src_wdata = sp_inc;
          end
          OPC_POP: begin
            src_we = 1'b1;
            src_waddr = AW'(s_r);
            src_wdata = a_r;
          end
          default: ;
        endcase
      end
      ST_X_W2: begin
        src_we = 1'b1;
        case (opc_r)
          OPC_RET: begin
            src_waddr = AW'(csp_r);
            src_wdata = '0;
            csp_nxt = csp_r - 1'b1;
          end
          OPC_CALL: begin
            src_waddr = AW'(IP_WORD);
            src_wdata = s_r;
          end
          OPC_PUSH: begin
            src_waddr = AW'(sp_inc);
            src_wdata = a_r;
          end
          default: begin
            // pop: the stack word may just have been the pop target
            src_waddr = AW'(SP_WORD);
            src_wdata = ((s_r == W'(SP_WORD)) ? a_r : sp_r) - 1'b1;
          end
        endcase
      end
      ST_INC_RD: src_raddr = AW'(IP_WORD);
      ST_INC_WR: begin
        src_we = 1'b1;
        src_waddr = AW'(IP_WORD);
        src_wdata = src_q + 1'b1;
      end
      ST_FIN_RD: src_raddr = AW'(IP_WORD);
      ST_FIN: begin
        out_strobe_nxt = 1'b1;
        out_res_nxt.out_valid = valid_r;
        out_res_nxt.out_is_char = char_r;
        out_res_nxt.out_value = 32'(outv_r);
        out_res_nxt.input_taken = taken_r;
        out_res_nxt.running = in_rng(CW'(src_q), plen_r);
        out_res_nxt.fault = fault_r;
        out_res_nxt.next_ip = 32'(src_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      plen_r <= '0;
      csp_r <= '0;
      csp_start_r <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      plen_r <= plen_nxt;
      csp_r <= csp_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we) begin
        csp_start_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    ip_r <= ip_nxt;
    opc_r <= opc_nxt;
    d_r <= d_nxt;
    s_r <= s_nxt;
    sp_r <= sp_nxt;
    a_r <= a_nxt;
    b_r <= b_nxt;
    flagd_r <= flagd_nxt;
    outv_r <= outv_nxt;
    valid_r <= valid_nxt;
    char_r <= char_nxt;
    taken_r <= taken_nxt;
    fault_r <= fault_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_res = out_res_r;

endmodule

[hw/rtl/twm_checker.sv]
module twm_checker import twm_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input logic     out_strobe,
  input out_res_t out_res
);

  a_idle_after_reset: assert property (@(posedge clk) !rst_n |=> !busy)
    else $error("busy after reset");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("request taken but not busy");

  a_result_follows_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result without a request in work");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe longer than one cycle");

  a_output_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_res.out_valid |-> out_res.fault == FLT_NONE)
    else $error("output value reported together with a fault");

endmodule

bind triple_word_machine_core twm_checker u_twm_checker (.*);

[tb/sv/tb_triple_word_machine_core.sv]
`timescale 1ns / 1ps

module tb_triple_word_machine_core;
  import twm_pkg::*;

  localparam int MEM_DEPTH = 1024;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic                   clk;
  logic                   rst_n;
  logic                   start;
  logic                   busy;
  in_req_t                in_req;
  logic                   out_strobe;
  out_res_t               out_res;
  logic                   cfg_we;
  logic [CSP_START_W-1:0] cfg_wdata;

  triple_word_machine_core #(.MEM_DEPTH(MEM_DEPTH), .WORD_WIDTH(32)) u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_strobe(out_strobe), .out_res(out_res), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // machine state as predicted
  logic [7:0]             mem_opc [MEM_DEPTH];
  logic [31:0]            mem_dst [MEM_DEPTH];
  logic [31:0]            mem_src [MEM_DEPTH];
  logic [31:0]            prog_len;
  logic [31:0]            call_sp;
  logic [CSP_START_W-1:0] call_sp_start;
  // ip word holds a defined value once appended or set by a start
  logic                   ip_known;

  out_res_t expected_q[$];
  logic     ip_known_q[$];
  int       mismatches;

  function automatic void post_expected(input out_res_t o, input logic known);
    expected_q = {expected_q, o};
    ip_known_q = {ip_known_q, known};
  endfunction

  function automatic logic in_mem(input logic [31:0] x);
    return x < prog_len;
  endfunction

  function automatic logic [1:0] run_insn(input logic [31:0] ip, input logic [31:0] inval,
                                          inout out_res_t o);
    logic [7:0]  k;
    logic [31:0] d, s, t, c, data;
    k = mem_opc[ip];
    d = mem_dst[ip];
    s = mem_src[ip];
    case (k)
      OPC_NOP, OPC_NOPB: begin
        mem_src[IP_WORD] += 1;
      end
      OPC_SKIP: begin
        if (!in_mem(s)) return FLT_RANGE;
        mem_src[IP_WORD] = mem_src[IP_WORD] + s + 1;
      end
      OPC_MOV, OPC_ADD, OPC_SUB, OPC_CMP, OPC_JCC: begin
        if (!in_mem(d) || !in_mem(s)) return FLT_RANGE;
        case (k)
          OPC_MOV: mem_src[d] = mem_src[s];
          OPC_ADD: mem_src[d] = mem_src[d] + mem_src[s];
          OPC_SUB: mem_src[d] = mem_src[d] - mem_src[s];
          OPC_CMP: begin
            mem_dst[FLAG_WORD] = (mem_src[d] == mem_src[s]) ? 32'd1 : 32'd0;
            mem_src[FLAG_WORD] = (mem_src[d] == mem_src[s]) ? 32'd0 : 32'd1;
          end
          default: begin
            mem_src[IP_WORD] = (mem_dst[FLAG_WORD] == 1 && mem_src[FLAG_WORD] == 0) ? d : s;
            return FLT_NONE;
          end
        endcase
        mem_src[IP_WORD] += 1;
      end
      OPC_SET: begin
        if (!in_mem(d)) return FLT_RANGE;
        mem_src[d] = s;
        mem_src[IP_WORD] += 1;
      end
      OPC_IN, OPC_OUT, OPC_INC, OPC_DEC, OPC_NOPC, OPC_NOPD: begin
        if (!in_mem(s)) return FLT_RANGE;
        case (k)
          OPC_IN: begin
            mem_src[s] = inval;
            o.input_taken = 1'b1;
          end
          OPC_OUT: begin
            o.out_value = mem_src[s];
            o.out_valid = 1'b1;
          end
          OPC_INC: mem_src[s] += 1;
          OPC_DEC: mem_src[s] -= 1;
          default: ;
        endcase
        mem_src[IP_WORD] += 1;
      end
      OPC_JBK: begin
        if (!in_mem(s) || !in_mem(ip - s)) return FLT_RANGE;
        mem_src[IP_WORD] = ip - s;
      end
      OPC_JFW: begin
        if (!in_mem(s) || !in_mem(ip + s)) return FLT_RANGE;
        mem_src[IP_WORD] = ip + s;
      end
      OPC_OUTC: begin
        o.out_value = {24'd0, s[7:0]};
        o.out_valid = 1'b1;
        o.out_is_char = 1'b1;
        mem_src[IP_WORD] += 1;
      end
      OPC_RET: begin
        if (!in_mem(call_sp)) return FLT_RANGE;
        mem_src[IP_WORD] = mem_src[call_sp];
        mem_src[call_sp] = 32'd0;
        call_sp = call_sp - 1;
        mem_src[IP_WORD] += 1;
      end
      OPC_CALL: begin
        c = call_sp + 1;
        if (!in_mem(s) || !in_mem(c)) return FLT_RANGE;
        call_sp = c;
        mem_src[c] = mem_src[IP_WORD];
        mem_src[IP_WORD] = s;
        mem_src[IP_WORD] += 1;
      end
      OPC_PUSH: begin
        t = mem_src[SP_WORD] + 1;
        if (!in_mem(s) || !in_mem(t)) return FLT_RANGE;
        data = mem_src[s];
        mem_src[SP_WORD] = t;
        mem_src[t] = data;
        mem_src[IP_WORD] += 1;
      end
      OPC_POP: begin
        t = mem_src[SP_WORD];
        if (!in_mem(s) || !in_mem(t)) return FLT_RANGE;
        mem_src[s] = mem_src[t];
        mem_src[SP_WORD] = mem_src[SP_WORD] - 1;
        mem_src[IP_WORD] += 1;
      end
      default: return FLT_OPCODE;
    endcase
    return FLT_NONE;
  endfunction

  function automatic out_res_t predict_machine(input in_req_t r);
    out_res_t    o;
    logic [31:0] ip;
    o = '0;
    case (r.op)
      REQ_APPEND: begin
        if (prog_len >= MEM_DEPTH) begin
          o.fault = FLT_FULL;
        end else begin
          mem_opc[prog_len] = r.word_opcode;
          mem_dst[prog_len] = r.word_dest;
          mem_src[prog_len] = r.word_source;
          prog_len += 1;
        end
      end
      REQ_START: begin
        mem_src[IP_WORD] = 32'd0;
        mem_src[SP_WORD] = SP_START;
        call_sp = {22'd0, call_sp_start};
      end
      REQ_EXEC: begin
        ip = mem_src[IP_WORD];
        if (in_mem(ip)) o.fault = run_insn(ip, r.input_value, o);
      end
      default: ;
    endcase
    if (r.op == REQ_START || prog_len > IP_WORD) ip_known = 1'b1;
    ip = mem_src[IP_WORD];
    o.running = in_mem(ip);
    o.next_ip = ip;
    return o;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // called right after a rising edge; returns right after the accepting edge
  task automatic send_request(input in_req_t r, input int gap);
    out_res_t o;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    in_req <= r;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    o = predict_machine(r);
    post_expected(o, ip_known);
  endtask

  function automatic logic [31:0] pick_operand();
    int p;
    p = $urandom_range(0, 99);
    if (p < 80) return $urandom_range(0, prog_len + 3);
    if (p < 90) return $urandom;
    return (p < 95) ? 32'd0 : 32'hFFFF_FFFF;
  endfunction

  task automatic send_word(input logic [7:0] opc, input logic [31:0] d, input logic [31:0] s);
    in_req_t r;
    r = '0;
    r.op = REQ_APPEND;
    r.word_opcode = opc;
    r.word_dest = d;
    r.word_source = s;
    r.input_value = $urandom;
    send_request(r, pick_gap());
  endtask

  task automatic send_random_word();
    logic [7:0] opc;
    opc = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(22, 255)) : 8'($urandom_range(0, 21));
    send_word(opc, pick_operand(), pick_operand());
  endtask

  task automatic send_ctrl(input logic [1:0] op, input logic [31:0] inval);
    in_req_t r;
    r = '0;
    r.op = op;
    r.word_opcode = $urandom;
    r.word_dest = $urandom;
    r.word_source = $urandom;
    r.input_value = inval;
    send_request(r, pick_gap());
  endtask

  task automatic write_call_base(input logic [CSP_START_W-1:0] v);
    start <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    call_sp_start = v;
  endtask

  // words 0 to 10 must exist before anything reads the fixed words
  task automatic test_base_image();
    for (int i = 0; i < 22; i++)
      send_word(8'(i), $urandom_range(0, 23), $urandom_range(0, 23));
    send_word(8'd22, 32'd0, 32'hFFFF_FFFF);
    send_word(8'd255, 32'hFFFF_FFFF, 32'd0);
  endtask

  task automatic test_directed_run();
    send_word(OPC_SET, 32'd5, 32'hFFFF_FFFF);
    send_word(OPC_SET, 32'hFFFF_FFFF, 32'd0);
    send_ctrl(REQ_START, 32'd0);
    for (int i = 0; i < 20; i++)
      send_ctrl(REQ_EXEC, (i % 2) ? 32'hFFFF_FFFF : 32'd0);
    send_ctrl(REQ_UNUSED, $urandom);
  endtask

  task automatic test_random_program(input int n);
    int p;
    send_ctrl(REQ_START, $urandom);
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(0, 99);
      if (!in_mem(mem_src[IP_WORD]) && p < 30) send_ctrl(REQ_START, $urandom);
      else if (p < 6) send_random_word();
      else if (p < 8) send_ctrl(REQ_START, $urandom);
      else if (p < 9) send_ctrl(REQ_UNUSED, $urandom);
      else send_ctrl(REQ_EXEC, $urandom);
    end
  endtask

  task automatic test_memory_full();
    while (prog_len < MEM_DEPTH) send_random_word();
    for (int i = 0; i < 3; i++) send_random_word();
    send_ctrl(REQ_START, $urandom);
    for (int i = 0; i < 60; i++) send_ctrl(REQ_EXEC, $urandom);
  endtask

  always @(negedge clk) begin
    out_res_t want;
    logic     ip_ok;
    if (rst_n && out_strobe) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_res);
      end else begin
        want = expected_q.pop_front();
        ip_ok = ip_known_q.pop_front();
        if (out_res.out_valid !== want.out_valid || out_res.out_is_char !== want.out_is_char ||
            out_res.out_value !== want.out_value || out_res.input_taken !== want.input_taken ||
            out_res.fault !== want.fault ||
            (ip_ok && (out_res.running !== want.running ||
                       out_res.next_ip !== want.next_ip))) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", want, out_res);
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    mismatches    = 0;
    prog_len      = 0;
    call_sp       = 0;
    call_sp_start = '0;
    ip_known      = 1'b0;
    for (int i = 0; i < MEM_DEPTH; i++) begin
      mem_opc[i] = '0;
      mem_dst[i] = '0;
      mem_src[i] = '0;
    end
    rst_n     = 1'b0;
    start     = 1'b0;
    in_req    = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_call_base(10'd1023);
    test_base_image();
    test_directed_run();
    test_random_program(200);
    write_call_base(10'd12);
    test_random_program(400);
    write_call_base(10'd0);
    test_random_program(300);
    write_call_base(10'($urandom_range(0, 40)));
    test_memory_full();

    start <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/twm_pkg.sv
hw/rtl/twm_store.sv
hw/rtl/triple_word_machine_core.sv
hw/rtl/twm_checker.sv
tb/sv/tb_triple_word_machine_core.sv
